>>> rtl/gradient_noise_2d_macros.svh
// Assertion macros used by the checker of the gradient noise block.
`ifndef GRADIENT_NOISE_2D_MACROS_SVH
`define GRADIENT_NOISE_2D_MACROS_SVH

// Clocked check, switched off while reset is held.
`define GN2_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gradient noise check failed");

// Clocked check that also holds across reset.
`define GN2_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gradient noise reset check failed");

`endif

>>> rtl/gn2_pkg.sv
// Types, constants and helper functions of the gradient noise block.
`default_nettype none
package gn2_pkg;

  localparam int TABLE_BITS    = 8;
  localparam int FRACTION_BITS = 16;
  localparam int TBL_DEPTH     = 1 << TABLE_BITS;
  localparam int FRAC_DN       = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
  localparam int FRAC_UP       = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
  localparam int DOT_W         = 20;
  localparam int FADE_W        = 17;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef logic [TABLE_BITS-1:0] tbl_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  table_index;
    logic [7:0]  table_value;
    logic [23:0] x_coord;
    logic [23:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] noise_value;
    logic [7:0]         brightness;
  } out_item_t;

  // Bring the coordinate fraction to Q16.
  function automatic logic [15:0] frac_q16(input logic [23:0] c);
    logic [31:0] f;
    begin
      f = 32'(c[FRACTION_BITS-1:0]);
      return 16'((f >> FRAC_DN) << FRAC_UP);
    end
  endfunction

  // Integer cell, wrapped to the table size.
  function automatic tbl_t cell_index(input logic [23:0] c);
    return TABLE_BITS'(c >> FRACTION_BITS);
  endfunction

  // Dot product of a diagonal gradient with the corner offset.
  function automatic logic signed [DOT_W-1:0] corner_dot(input logic [1:0] h,
                                                          input logic signed [16:0] dx,
                                                          input logic signed [16:0] dy);
    logic signed [DOT_W-1:0] ex, ey, sx, sy;
    begin
      ex = DOT_W'(dx);
      ey = DOT_W'(dy);
      sx = (h == 2'd0 || h == 2'd3) ? ex : -ex;
      sy = (h == 2'd0 || h == 2'd1) ? ey : -ey;
      return sx + sy;
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/gradient_noise_2d.sv
// Top level of the two-dimensional gradient noise pipeline.
// An accepted evaluate item passes stage registers v1_r to v6_r, then the output register.
// Throughput: one item per cycle unless stalled; three table copies, two read ports each.
// A load item writes all three copies as it passes and yields no result.
// Reset (synchronous, rst_n low) empties the pipeline; the table keeps its contents.
`default_nettype none
module gradient_noise_2d import gn2_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic en;
  logic accept;

  logic        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic        op1_r, op2_r, op3_r, op4_r, op5_r, op6_r;
  tbl_t        idx1_r, val1_r, yi1_r, yj1_r;
  logic [15:0] xf1_r, yf1_r, xf2_r, yf2_r;

  tbl_t pa, pb, h_bl, h_tl, h_br, h_tr;
  tbl_t xi, yi;

  logic signed [DOT_W-1:0] d_bl_r, d_br_r, d_tl_r, d_tr_r;
  logic signed [DOT_W-1:0] lo, hi, n16;
  logic [FADE_W-1:0]       fu, fv, u4_r;
  logic signed [16:0]      dx0, dx1, dy0, dy1;
  logic signed [DOT_W-1:0] n14_w;
  logic signed [15:0]      n14_r;
  logic signed [17:0]      s;
  logic [25:0]             br_full;
  logic [7:0]              br;
  logic                    wr2;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;
  assign xi       = cell_index(in_data.x_coord);
  assign yi       = cell_index(in_data.y_coord);
  assign wr2      = en && v1_r && (op1_r == OP_LOAD);

  // First hash level: P[xi] and P[xi+1].
  gn2_ram #(.ADDR_W(TABLE_BITS), .DATA_W(TABLE_BITS)) u_ram1 (
    .clk(clk), .we(accept && (in_data.op == OP_LOAD)),
    .waddr(TABLE_BITS'(in_data.table_index)), .wdata(TABLE_BITS'(in_data.table_value)),
    .re(en), .raddr_a(xi), .raddr_b(tbl_t'(xi + tbl_t'(1))),
    .rdata_a(pa), .rdata_b(pb)
  );

  // Second hash level, written from the stage-1 registers to keep order with reads.
  gn2_ram #(.ADDR_W(TABLE_BITS), .DATA_W(TABLE_BITS)) u_ram2 (
    .clk(clk), .we(wr2), .waddr(idx1_r), .wdata(val1_r),
    .re(en), .raddr_a(tbl_t'(pa + yi1_r)), .raddr_b(tbl_t'(pa + yj1_r)),
    .rdata_a(h_bl), .rdata_b(h_tl)
  );

  gn2_ram #(.ADDR_W(TABLE_BITS), .DATA_W(TABLE_BITS)) u_ram3 (
    .clk(clk), .we(wr2), .waddr(idx1_r), .wdata(val1_r),
    .re(en), .raddr_a(tbl_t'(pb + yi1_r)), .raddr_b(tbl_t'(pb + yj1_r)),
    .rdata_a(h_br), .rdata_b(h_tr)
  );

  gn2_fade u_fade_x (.clk(clk), .en(en), .t(frac_q16(in_data.x_coord)), .fade(fu));
  gn2_fade u_fade_y (.clk(clk), .en(en), .t(frac_q16(in_data.y_coord)), .fade(fv));

  gn2_lerp u_lerp_lo (.clk(clk), .en(en), .t(fv), .a(d_bl_r), .b(d_tl_r), .y(lo));
  gn2_lerp u_lerp_hi (.clk(clk), .en(en), .t(fv), .a(d_br_r), .b(d_tr_r), .y(hi));
  gn2_lerp u_lerp_n  (.clk(clk), .en(en), .t(u4_r), .a(lo), .b(hi), .y(n16));

  always_comb begin
    dx0 = $signed({1'b0, xf2_r});
    dy0 = $signed({1'b0, yf2_r});
    // Far-corner offset: fraction minus one.
    dx1 = $signed({1'b1, xf2_r});
    dy1 = $signed({1'b1, yf2_r});
    n14_w = (n16 + DOT_W'(2)) >>> 2;
    s = 18'(n14_r) + 18'sd16384;
    br_full = 26'(s) * 26'd255;
    if (s <= 18'sd0) begin
      br = 8'd0;
    end else if (br_full[25:15] > 11'd255) begin
      br = 8'd255;
    end else begin
      br = br_full[22:15];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      v5_r      <= 1'b0;
      v6_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= v4_r;
      v6_r      <= v5_r;
      out_valid <= v6_r && (op6_r == OP_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r  <= in_data.op;
      idx1_r <= TABLE_BITS'(in_data.table_index);
      val1_r <= TABLE_BITS'(in_data.table_value);
      yi1_r  <= yi;
      yj1_r  <= tbl_t'(yi + tbl_t'(1));
      xf1_r  <= frac_q16(in_data.x_coord);
      yf1_r  <= frac_q16(in_data.y_coord);
      op2_r  <= op1_r;
      xf2_r  <= xf1_r;
      yf2_r  <= yf1_r;
      op3_r  <= op2_r;
      d_bl_r <= corner_dot(h_bl[1:0], dx0, dy0);
      d_br_r <= corner_dot(h_br[1:0], dx1, dy0);
      d_tl_r <= corner_dot(h_tl[1:0], dx0, dy1);
      d_tr_r <= corner_dot(h_tr[1:0], dx1, dy1);
      op4_r  <= op3_r;
      u4_r   <= fu;
      op5_r  <= op4_r;
      op6_r  <= op5_r;
      // Saturate to Q2.14.
      if (n14_w > DOT_W'(32767)) begin
        n14_r <= 16'sh7fff;
      end else if (n14_w < -DOT_W'(32768)) begin
        n14_r <= -16'sh8000;
      end else begin
        n14_r <= 16'(n14_w);
      end
      out_data.noise_value <= n14_r;
      out_data.brightness  <= br;
    end
  end

endmodule
`default_nettype wire

>>> rtl/gn2_ram.sv
// Permutation table copy: one write port, two registered read ports.
`default_nettype none
module gn2_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [DATA_W-1:0] rdata_a,
  output logic      [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

>>> rtl/gn2_fade.sv
// Three-stage fade curve 6t^5-15t^4+10t^3 in Q16.
`default_nettype none
module gn2_fade import gn2_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [15:0]       t,
  output logic      [FADE_W-1:0] fade
);

  logic [15:0] t_r;
  logic [31:0] t2_r;
  logic [19:0] q16_r;
  logic [31:0] cube_r;
  logic [36:0] quad;
  logic [47:0] cube_full;
  logic [52:0] prod;

  always_comb begin
    quad      = (37'd10 << 32) + 37'(t2_r) * 37'd6 - ((37'(t_r) * 37'd15) << 16);
    cube_full = 48'(t2_r) * 48'(t_r);
    prod      = 53'(cube_r) * 53'(q16_r) + (53'd1 << 31);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= t;
      t2_r   <= 32'(t) * 32'(t);
      q16_r  <= quad[35:16];
      cube_r <= cube_full[47:16];
      fade   <= prod[48:32];
    end
  end

endmodule
`default_nettype wire

>>> rtl/gn2_lerp.sv
// Registered linear blend a + round(t*(b-a)) in Q16.
`default_nettype none
module gn2_lerp import gn2_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic        [FADE_W-1:0] t,
  input  wire logic signed [DOT_W-1:0]  a,
  input  wire logic signed [DOT_W-1:0]  b,
  output logic      signed [DOT_W-1:0]  y
);

  logic signed [DOT_W:0]          diff;
  logic signed [DOT_W+FADE_W+1:0] prod;
  logic signed [DOT_W+FADE_W+1:0] step;

  always_comb begin
    diff = (DOT_W + 1)'(b) - (DOT_W + 1)'(a);
    prod = (DOT_W + FADE_W + 2)'($signed({1'b0, t})) * (DOT_W + FADE_W + 2)'(diff)
           + (DOT_W + FADE_W + 2)'(32768);
    step = prod >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= a + DOT_W'(step);
    end
  end

endmodule
`default_nettype wire

>>> rtl/gradient_noise_2d_checker.sv
// Port-level checker for the gradient noise block, bound to the top level.
`default_nettype none
`include "gradient_noise_2d_macros.svh"
module gradient_noise_2d_checker import gn2_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  `GN2_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)
  `GN2_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `GN2_ASSERT(a_ready_when_empty, !out_valid |-> in_ready)
  `GN2_ASSERT(a_ready_when_taken, out_valid && out_ready |-> in_ready)
  `GN2_ASSERT(a_dark_floor,
    out_valid && (out_data.noise_value <= -16'sd16384) |-> out_data.brightness == 8'd0)

endmodule

bind gradient_noise_2d gradient_noise_2d_checker u_checker (.*);
`default_nettype wire
